[rtl/gfmix_pkg.sv]
// Package for the GF(2^8) column mixer: constants, types and the byte multiplier.
`timescale 1ns / 1ps
`default_nettype none
package gfmix_pkg;

  // Matrix size: bytes per column and rows of coefficients
  localparam int unsigned Rows = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ColW = Rows * ByteW;

  // Low byte of the reduction polynomial x^8+x^4+x^3+x+1
  localparam logic [ByteW-1:0] ReducePoly = 8'h1b;

  // Coefficient register indexes
  typedef enum logic [1:0] {
    CFG_ROW0 = 2'd0,
    CFG_ROW1 = 2'd1,
    CFG_ROW2 = 2'd2,
    CFG_ROW3 = 2'd3
  } cfg_idx_t;

  // Reset matrix (forward MixColumns)
  localparam logic [ColW-1:0] CoeffRow0Rst = 32'h0203_0101;
  localparam logic [ColW-1:0] CoeffRow1Rst = 32'h0102_0301;
  localparam logic [ColW-1:0] CoeffRow2Rst = 32'h0101_0203;
  localparam logic [ColW-1:0] CoeffRow3Rst = 32'h0301_0102;

  typedef logic [Rows-1:0][ByteW-1:0] byte_vec_t;

  // Data handed from cell to cell: remaining column bytes and row sums
  typedef struct packed {
    logic [ColW-1:0] col;  // next byte to use sits in the low bits
    byte_vec_t       acc;  // running XOR sum of each output row
  } stage_t;

  // Carry-less multiply of two bytes reduced modulo 0x11b
  function automatic logic [ByteW-1:0] gf_mul(input logic [ByteW-1:0] a,
                                              input logic [ByteW-1:0] b);
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] sh;
    acc = '0;
    sh  = a;
    for (int i = 0; i < ByteW; i++) begin
      if (b[i]) begin
        acc = acc ^ sh;
      end
      sh = {sh[ByteW-2:0], 1'b0} ^ (sh[ByteW-1] ? ReducePoly : '0);
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

[rtl/gf256_matrix_column_mix_core.sv]
// Top level: GF(2^8) 4x4 matrix times column, built as a chain of four cells.
// An accepted request passes through all four cell registers, one cell per column byte, to out_tvalid.
// Throughput: one column per cycle while out_tready is high; each cell holds one request, and a stalled output
//   still lets earlier empty cells take new requests.
// Reset: clears all cell valid bits and loads the forward MixColumns matrix into the
//   coefficient registers.
`timescale 1ns / 1ps
`default_nettype none
module gf256_matrix_column_mix_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // in_byte0, in_byte1, in_byte2, in_byte3
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // out_byte0, out_byte1, out_byte2, out_byte3
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import gfmix_pkg::*;

  logic [Rows-1:0][ColW-1:0] coeff_r;
  logic [Rows:0]             vld;
  logic [Rows:0]             rdy;
  stage_t                    data [Rows+1];
  byte_vec_t                 cell_coeff [Rows];

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r[CFG_ROW0] <= CoeffRow0Rst;
      coeff_r[CFG_ROW1] <= CoeffRow1Rst;
      coeff_r[CFG_ROW2] <= CoeffRow2Rst;
      coeff_r[CFG_ROW3] <= CoeffRow3Rst;
    end else if (cfg_we) begin
      coeff_r[cfg_index] <= cfg_wdata;
    end
  end

  // Chain head: full column in, row sums start at zero
  assign vld[0]       = in_tvalid;
  assign in_tready    = rdy[0];
  assign data[0].col  = in_tdata;
  assign data[0].acc  = '0;

  // Cells: cell c takes column byte c, coefficients in bits 31-8c downward
  for (genvar c = 0; c < Rows; c++) begin : g_cell
    for (genvar r = 0; r < Rows; r++) begin : g_coeff
      assign cell_coeff[c][r] = coeff_r[r][ColW-1-ByteW*c -: ByteW];
    end

    gfmix_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[c]),
      .up_ready (rdy[c]),
      .up_data  (data[c]),
      .coeff    (cell_coeff[c]),
      .dn_valid (vld[c+1]),
      .dn_ready (rdy[c+1]),
      .dn_data  (data[c+1])
    );
  end

  // Chain tail is the output register
  assign out_tvalid = vld[Rows];
  assign rdy[Rows]  = out_tready;
  assign out_tdata  = data[Rows].acc;

  // A taken output frees the whole chain
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output was taken");

  // Full chain with a stalled output must refuse input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld[Rows:1] && !out_tready) |-> !in_tready)
    else $error("input accepted into a full chain");

  // A coefficient write lands in the addressed row
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> coeff_r[$past(cfg_index)] == $past(cfg_wdata))
    else $error("coefficient write lost");

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

[rtl/gfmix_cell.sv]
// One cell of the mixer chain: folds one column byte into all four row sums.
`timescale 1ns / 1ps
`default_nettype none
module gfmix_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  gfmix_pkg::stage_t   up_data,
  input  gfmix_pkg::byte_vec_t coeff,   // this column's coefficient of each row
  output logic                dn_valid,
  input  logic                dn_ready,
  output gfmix_pkg::stage_t   dn_data
);
  import gfmix_pkg::*;

  logic   valid_r;
  stage_t data_r;
  stage_t data_nxt;

  // Stage can load when empty or when its content moves on
  assign up_ready = !valid_r || dn_ready;

  // Multiply the low byte by each row coefficient, shift the column down
  always_comb begin
    data_nxt.col = {{ByteW{1'b0}}, up_data.col[ColW-1:ByteW]};
    for (int r = 0; r < Rows; r++) begin
      data_nxt.acc[r] = up_data.acc[r] ^ gf_mul(coeff[r], up_data.col[ByteW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
`default_nettype wire

[test/tb_gf256_matrix_column_mix_core.sv]
// Testbench for the GF(2^8) column mixer: streamed columns checked against a column predictor.
`timescale 1ns / 1ps
module tb_gf256_matrix_column_mix_core;
  import gfmix_pkg::*;

  localparam int unsigned Latency = 4;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldOffCycles = 150;
  localparam logic [8:0] FieldPoly = 9'h11b;

  // Inverse MixColumns matrix rows
  localparam logic [ColW-1:0] InvRow0 = 32'h0e0b_0d09;
  localparam logic [ColW-1:0] InvRow1 = 32'h090e_0b0d;
  localparam logic [ColW-1:0] InvRow2 = 32'h0d09_0e0b;
  localparam logic [ColW-1:0] InvRow3 = 32'h0b0d_090e;

  // Column predictor and queue of mixed columns still due
  class mix_scoreboard;
    logic [ColW-1:0] coeff [Rows];
    byte_vec_t       mixed_q [$];
    int              errors;

    function new();
      coeff[0] = CoeffRow0Rst;
      coeff[1] = CoeffRow1Rst;
      coeff[2] = CoeffRow2Rst;
      coeff[3] = CoeffRow3Rst;
      errors = 0;
    endfunction

    function void set_coeff(int unsigned row, logic [ColW-1:0] value);
      coeff[row] = value;
    endfunction

    // Shift-and-add product, reducing whenever bit 8 appears
    function logic [ByteW-1:0] field_product(logic [ByteW-1:0] a, logic [ByteW-1:0] b);
      logic [8:0]       sh;
      logic [ByteW-1:0] acc;
      acc = '0;
      sh  = {1'b0, a};
      for (int i = 0; i < ByteW; i++) begin
        if (b[i]) begin
          acc ^= sh[ByteW-1:0];
        end
        sh = sh << 1;
        if (sh[8]) begin
          sh ^= FieldPoly;
        end
      end
      return acc;
    endfunction

    function byte_vec_t mix_column(byte_vec_t col);
      byte_vec_t        res;
      logic [ByteW-1:0] k;
      for (int r = 0; r < Rows; r++) begin
        res[r] = '0;
        for (int c = 0; c < Rows; c++) begin
          // first column byte sits in the top bits of the row register
          k = coeff[r][ColW-1-ByteW*c -: ByteW];
          res[r] ^= field_product(k, col[c]);
        end
      end
      return res;
    endfunction

    function void note_request(logic [ColW-1:0] data);
      mixed_q.push_back(mix_column(byte_vec_t'(data)));
    endfunction

    function void check_result(logic [ColW-1:0] data);
      byte_vec_t got;
      byte_vec_t want;
      got = byte_vec_t'(data);
      if (mixed_q.size() == 0) begin
        $error("unexpected result %h with nothing outstanding", data);
        errors++;
        return;
      end
      want = mixed_q.pop_front();
      for (int r = 0; r < Rows; r++) begin
        if (got[r] !== want[r]) begin
          $error("out_byte%0d: expected %h, actual %h", r, want[r], got[r]);
          errors++;
        end
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [ColW-1:0] in_tdata = '0;   // in_byte0, in_byte1, in_byte2, in_byte3
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [ColW-1:0] out_tdata;       // out_byte0, out_byte1, out_byte2, out_byte3
  logic            cfg_we = 1'b0;
  logic [1:0]      cfg_index = '0;
  logic [ColW-1:0] cfg_wdata = '0;

  mix_scoreboard   sb = new();
  bit              calm = 1'b0;        // no idling on either side
  bit              hold_off_req = 1'b0;
  logic [ColW-1:0] corner_cols [$];

  always #10 clk = ~clk;

  gf256_matrix_column_mix_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Offer one request and wait for it to be taken
  task automatic send_column(input logic [ColW-1:0] col);
    in_tvalid <= 1'b1;
    in_tdata  <= col;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(col);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    in_tvalid <= 1'b0;
    in_tdata  <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  // Mostly random bytes, sometimes built from corner values
  function automatic logic [ColW-1:0] pick_column();
    logic [ColW-1:0] col;
    logic [ByteW-1:0] corners [4];
    corners = '{8'h00, 8'hff, 8'h01, 8'h80};
    col = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      for (int c = 0; c < Rows; c++) begin
        col[ByteW*c +: ByteW] = corners[$urandom_range(0, 3)];
      end
    end
    return col;
  endfunction

  task automatic send_random(input int unsigned count, input bit gaps);
    for (int unsigned i = 0; i < count; i++) begin
      if (gaps && !calm && $urandom_range(0, 7) == 0) begin
        idle_sender($urandom_range(1, 19));
      end
      send_column(pick_column());
    end
  endtask

  // Stop offering and let every outstanding column come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.mixed_q.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  // Write all four coefficient rows, one per cycle
  task automatic load_matrix(input logic [ColW-1:0] r0, input logic [ColW-1:0] r1,
                             input logic [ColW-1:0] r2, input logic [ColW-1:0] r3);
    logic [ColW-1:0] rows [Rows];
    rows = '{r0, r1, r2, r3};
    for (int r = 0; r < Rows; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(r);
      cfg_wdata <= rows[r];
      @(posedge clk);
      sb.set_coeff(r, rows[r]);
    end
    cfg_we <= 1'b0;
  endtask

  // Coefficient word with a zero byte now and then
  function automatic logic [ColW-1:0] pick_coeff_row();
    logic [ColW-1:0] row;
    row = $urandom;
    for (int c = 0; c < Rows; c++) begin
      if ($urandom_range(0, 5) == 0) begin
        row[ByteW*c +: ByteW] = '0;
      end
    end
    return row;
  endfunction

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles without any accepted request or result
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= StallLimit) begin
        $display("timeout after %0d idle cycles", quiet);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    corner_cols = '{32'h0000_0000, 32'hffff_ffff, 32'h0101_0101, 32'h8080_8080,
                    32'h0000_00ff, 32'h0000_ff00, 32'h00ff_0000, 32'hff00_0000,
                    32'h4553_13db, 32'h5c22_0af2, 32'hc6c6_c6c6, 32'hd5d4_d4d4,
                    32'h4c31_262d, 32'h5a5a_5a5a, 32'ha5a5_a5a5};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Forward matrix from reset, corner columns back to back
    foreach (corner_cols[i]) send_column(corner_cols[i]);
    drain();

    // Inverse matrix; long receiver hold-off fills the pipeline
    load_matrix(InvRow0, InvRow1, InvRow2, InvRow3);
    send_random(40, 1'b1);
    hold_off_req = 1'b1;
    send_random(30, 1'b0);
    send_random(80, 1'b1);
    drain();

    // All-zero coefficients: every term drops out
    load_matrix('0, '0, '0, '0);
    send_column(32'hffff_ffff);
    send_random(30, 1'b1);
    drain();

    // All-ones coefficients
    load_matrix('1, '1, '1, '1);
    send_column(32'hffff_ffff);
    send_column(32'h0000_0000);
    send_random(60, 1'b1);
    drain();

    // Random matrices with some zero coefficients
    repeat (3) begin
      load_matrix(pick_coeff_row(), pick_coeff_row(), pick_coeff_row(), pick_coeff_row());
      send_random(90, 1'b1);
      drain();
    end

    // Forward matrix written back, then a gapless tail
    load_matrix(CoeffRow0Rst, CoeffRow1Rst, CoeffRow2Rst, CoeffRow3Rst);
    send_random(60, 1'b1);
    calm = 1'b1;
    send_random(60, 1'b0);
    drain();
    repeat (Latency) @(posedge clk);

    if (sb.errors == 0 && sb.mixed_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
